// ===== sv/bis_pkg.sv =====
package bis_pkg;

  localparam int DEF_MAX_SRC_WIDTH  = 256;
  localparam int DEF_MAX_SRC_HEIGHT = 256;
  localparam int DEF_FRACTION_BITS  = 8;

  localparam int POS_W     = 10;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int SRC_W     = 9;
  localparam int DST_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [SRC_W-1:0] SRC_SIZE_RESET = 9'd256;
  localparam logic [DST_W-1:0] DST_SIZE_RESET = 11'd256;

endpackage

// ===== sv/bis_ram.sv =====
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== sv/bilinear_image_scaler.sv =====
// Bilinear RGB scaler with a fully pipelined datapath.
// Compute transfers pass the input register, the NDS two-bit radix stages of the
// position divider (8 with the default sizes), the frame store read and the product
// register to the output register. Throughput: one item per cycle unless in_stall is set.
// Synchronous reset clears valid bits and sets all four size registers to 256;
// the frame store contents are undefined until written.
module bilinear_image_scaler
  import bis_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
  parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 action,
  input  logic [POS_W-1:0]     pos_x,
  input  logic [POS_W-1:0]     pos_y,
  input  logic [CH_W-1:0]      red_in,
  input  logic [CH_W-1:0]      green_in,
  input  logic [CH_W-1:0]      blue_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      red_out,
  output logic [CH_W-1:0]      green_out,
  output logic [CH_W-1:0]      blue_out,
  output logic                 position_ok
);

  localparam int F     = FRACTION_BITS;
  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int QXW   = XW + F;
  localparam int QYW   = YW + F;
  localparam int QMW   = (QXW > QYW) ? QXW : QYW;
  localparam int DB    = 2;
  localparam int NDS   = (QMW + DB - 1) / DB;
  localparam int DVW   = POS_W + SRC_W + F;
  localparam int W2    = 2 * F + 2;
  localparam int PW    = W2 + CH_W;
  localparam int SMW   = PW + 2;

  typedef struct packed {
    logic          act;
    logic          ok;
    logic          wen;
    logic [AW-1:0] waddr;
    logic [PIX_W-1:0] pix;
  } item_t;

  typedef logic [PW-1:0] prod_t [0:3][0:2];

  function automatic logic [SRC_W-1:0] clamp_size(input logic [SRC_W-1:0] v, input int mx);
    if (v == '0) begin
      return SRC_W'(1);
    end
    if (int'(v) > mx) begin
      return SRC_W'(mx);
    end
    return v;
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
    return AW'(32'(y) * MAX_SRC_WIDTH + 32'(x));
  endfunction

  logic [SRC_W-1:0] src_width;
  logic [SRC_W-1:0] src_height;
  logic [DST_W-1:0] dst_width;
  logic [DST_W-1:0] dst_height;
  logic [SRC_W-1:0] sw_c;
  logic [SRC_W-1:0] sh_c;
  logic             en;

  assign cfg_ready = 1'b1;
  assign sw_c      = clamp_size(src_width, MAX_SRC_WIDTH);
  assign sh_c      = clamp_size(src_height, MAX_SRC_HEIGHT);
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_SIZE_RESET;
      src_height <= SRC_SIZE_RESET;
      dst_width  <= DST_SIZE_RESET;
      dst_height <= DST_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= cfg_data[SRC_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[SRC_W-1:0];
        CFG_DST_WIDTH:  dst_width  <= cfg_data[DST_W-1:0];
        CFG_DST_HEIGHT: dst_height <= cfg_data[DST_W-1:0];
        default: ;
      endcase
    end
  end

  logic             vld   [0:NDS];
  item_t            it    [0:NDS];
  logic [DVW-1:0]   dv_x  [0:NDS];
  logic [DVW-1:0]   dv_y  [0:NDS];
  logic [DST_W-1:0] rem_x [0:NDS];
  logic [DST_W-1:0] rem_y [0:NDS];
  logic [QXW-1:0]   quo_x [0:NDS];
  logic [QYW-1:0]   quo_y [0:NDS];

  logic [DVW-1:0] dvd_x_next;
  logic [DVW-1:0] dvd_y_next;
  item_t          it_next;

  always_comb begin
    dvd_x_next = DVW'(pos_x * sw_c) << F;
    dvd_y_next = DVW'(pos_y * sh_c) << F;
    it_next.act   = action;
    it_next.ok    = ({1'b0, pos_x} < dst_width) && ({1'b0, pos_y} < dst_height);
    it_next.wen   = (action == ACT_LOAD) && (32'(pos_x) < MAX_SRC_WIDTH) &&
                    (32'(pos_y) < MAX_SRC_HEIGHT);
    it_next.waddr = pix_addr(YW'(pos_y), XW'(pos_x));
    it_next.pix   = {red_in, green_in, blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it[0]    <= it_next;
      dv_x[0]  <= dvd_x_next;
      dv_y[0]  <= dvd_y_next;
      rem_x[0] <= DST_W'(dvd_x_next >> QXW);
      rem_y[0] <= DST_W'(dvd_y_next >> QYW);
      quo_x[0] <= '0;
      quo_y[0] <= '0;
    end
  end

  for (genvar s = 0; s < NDS; s++) begin : g_div
    logic [DST_W-1:0] rx_next;
    logic [DST_W-1:0] ry_next;
    logic [QXW-1:0]   qx_next;
    logic [QYW-1:0]   qy_next;
    logic [DST_W:0]   tx;
    logic [DST_W:0]   ty;

    always_comb begin
      rx_next = rem_x[s];
      ry_next = rem_y[s];
      qx_next = quo_x[s];
      qy_next = quo_y[s];
      tx      = '0;
      ty      = '0;
      for (int j = 0; j < DB; j++) begin
        if (s * DB + j < QXW) begin
          tx = {rx_next, dv_x[s][QXW-1-(s*DB+j)]};
          if (tx >= {1'b0, dst_width}) begin
            tx = tx - {1'b0, dst_width};
            qx_next[QXW-1-(s*DB+j)] = 1'b1;
          end
          rx_next = tx[DST_W-1:0];
        end
        if (s * DB + j < QYW) begin
          ty = {ry_next, dv_y[s][QYW-1-(s*DB+j)]};
          if (ty >= {1'b0, dst_height}) begin
            ty = ty - {1'b0, dst_height};
            qy_next[QYW-1-(s*DB+j)] = 1'b1;
          end
          ry_next = ty[DST_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it[s+1]    <= it[s];
        dv_x[s+1]  <= dv_x[s];
        dv_y[s+1]  <= dv_y[s];
        rem_x[s+1] <= rx_next;
        rem_y[s+1] <= ry_next;
        quo_x[s+1] <= qx_next;
        quo_y[s+1] <= qy_next;
      end
    end
  end

  logic [XW-1:0] x0;
  logic [XW-1:0] x1;
  logic [YW-1:0] y0;
  logic [YW-1:0] y1;
  logic [F-1:0]  fx;
  logic [F-1:0]  fy;
  logic [F:0]    ofx;
  logic [F:0]    ofy;
  logic [F:0]    one_c;

  always_comb begin
    one_c = {1'b1, {F{1'b0}}};
    x0    = quo_x[NDS][QXW-1 -: XW];
    y0    = quo_y[NDS][QYW-1 -: YW];
    fx    = quo_x[NDS][F-1:0];
    fy    = quo_y[NDS][F-1:0];
    ofx   = one_c - {1'b0, fx};
    ofy   = one_c - {1'b0, fy};
    if (32'(x0) + 32'd1 < 32'(sw_c)) begin
      x1 = x0 + XW'(1);
    end else begin
      x1 = x0;
    end
    if (32'(y0) + 32'd1 < 32'(sh_c)) begin
      y1 = y0 + YW'(1);
    end else begin
      y1 = y0;
    end
  end

  logic [PIX_W-1:0] p00;
  logic [PIX_W-1:0] p01;
  logic [PIX_W-1:0] p10;
  logic [PIX_W-1:0] p11;
  logic             wr_en;

  assign wr_en = en && vld[NDS] && it[NDS].wen;

  bis_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_upper (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (it[NDS].waddr),
    .wr_data   (it[NDS].pix),
    .rd_en     (en),
    .rd_addr_a (pix_addr(y0, x0)),
    .rd_addr_b (pix_addr(y0, x1)),
    .rd_data_a (p00),
    .rd_data_b (p01)
  );

  bis_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram_lower (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (it[NDS].waddr),
    .wr_data   (it[NDS].pix),
    .rd_en     (en),
    .rd_addr_a (pix_addr(y1, x0)),
    .rd_addr_b (pix_addr(y1, x1)),
    .rd_data_a (p10),
    .rd_data_b (p11)
  );

  logic          vld_r;
  item_t         it_r;
  logic [W2-1:0] wt [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld[NDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r  <= it[NDS];
      wt[0] <= W2'(ofx) * W2'(ofy);
      wt[1] <= W2'(fx) * W2'(ofy);
      wt[2] <= W2'(ofx) * W2'(fy);
      wt[3] <= W2'(fx) * W2'(fy);
    end
  end

  logic [PIX_W-1:0] pix_r [0:3];
  logic             vld_p;
  item_t            it_p;
  prod_t            prod;

  assign pix_r[0] = p00;
  assign pix_r[1] = p01;
  assign pix_r[2] = p10;
  assign pix_r[3] = p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
    end else if (en) begin
      vld_p <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_p <= it_r;
      for (int n = 0; n < 4; n++) begin
        for (int k = 0; k < 3; k++) begin
          prod[n][k] <= PW'(wt[n]) * PW'(pix_r[n][PIX_W-1-CH_W*k -: CH_W]);
        end
      end
    end
  end

  logic [SMW-1:0]  sum [0:2];
  logic [CH_W-1:0] chan [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SMW'(prod[0][k]) + SMW'(prod[1][k]) + SMW'(prod[2][k]) + SMW'(prod[3][k]);
      chan[k] = it_p.ok ? sum[k][2*F +: CH_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_p && (it_p.act == ACT_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out     <= chan[0];
      green_out   <= chan[1];
      blue_out    <= chan[2];
      position_ok <= it_p.ok;
    end
  end

endmodule

// ===== sv/bis_checker.sv =====
module bis_checker
  import bis_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 action,
  input logic [POS_W-1:0]     pos_x,
  input logic [POS_W-1:0]     pos_y,
  input logic [CH_W-1:0]      red_in,
  input logic [CH_W-1:0]      green_in,
  input logic [CH_W-1:0]      blue_in,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [CH_W-1:0]      red_out,
  input logic [CH_W-1:0]      green_out,
  input logic [CH_W-1:0]      blue_out,
  input logic                 position_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transfer dropped while stalled");

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !position_ok |-> red_out == '0 && green_out == '0 && blue_out == '0)
    else $error("out-of-range pixel is not black");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);
